// ----- sv/flpw_pkg.sv -----
// Shared types and constants for the four-level page walker.
`timescale 1ns / 1ps

package flpw_pkg;

    localparam int unsigned VA_W   = 48;
    localparam int unsigned DATA_W = 64;
    localparam int unsigned LVL_W  = 2;
    localparam int unsigned CFG_IDX_W = 2;

    // Entry bits that matter to the walk.
    localparam int unsigned VALID_POS = 0;
    localparam int unsigned LARGE_POS = 7;

    localparam logic [LVL_W-1:0] TOP_LEVEL  = 2'd0;
    localparam logic [LVL_W-1:0] LAST_LEVEL = 2'd3;

    typedef enum logic
    {
        OP_TRANSLATE = 1'b0,
        OP_RESPONSE  = 1'b1
    } opcode_t;

    typedef enum logic
    {
        KIND_READ = 1'b0,
        KIND_DONE = 1'b1
    } result_kind_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_PTE_BASE = 2'd0,
        REG_PDE_BASE = 2'd1,
        REG_PPE_BASE = 2'd2,
        REG_PXE_BASE = 2'd3
    } cfg_index_t;

    typedef struct packed
    {
        opcode_t             opcode;
        logic [VA_W-1:0]     virt_addr;
        logic [DATA_W-1:0]   entry_data;
    } walk_item_t;

    typedef struct packed
    {
        result_kind_t        result_kind;
        logic [DATA_W-1:0]   read_addr;
        logic [DATA_W-1:0]   phys_addr;
        logic                not_present;
    } walk_result_t;

endpackage

// ----- sv/flpw_chan_if.sv -----
// Valid/ready channel interface that carries one payload per transaction.
`timescale 1ns / 1ps

interface flpw_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source
    (
        output valid,
        output payload,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  payload,
        output ready
    );
endinterface

// ----- sv/four_level_page_walker.sv -----
// Top level of the four-level page walker: input stage, walk logic and result register.
`timescale 1ns / 1ps

// The walker translates a 48-bit virtual address through four page table
// levels reached by a recursive self-map. A translate transaction on cmd
// (opcode OP_TRANSLATE) starts a walk and produces a read request for the
// top-level entry on res; every response transaction (opcode OP_RESPONSE)
// either produces the read request for the next level or finishes the walk
// with the physical address, or with not_present set when an entry was
// invalid. A translate that arrives during a walk, and a response that
// arrives while idle, are dropped and give no result. The block takes one
// transaction per clock cycle while it is not held back by a full result
// register: a transaction is first captured in an input register, and from
// there the entry address add or the frame plus offset add is done and
// written into the result register, which offers the result on res. The
// result register frees the input side: a new transaction is taken while a
// result waits to be taken, and only a full result register that is not
// being drained holds back the stage that is about to produce a result. The
// user must write the four base registers through the cfg port only while no
// walk is in progress; the block itself does not enforce this.
module four_level_page_walker
    import flpw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DATA_W-1:0]     cfg_data,

    flpw_chan_if.sink             cmd,
    flpw_chan_if.source           res
);

    // Configuration registers.
    logic [DATA_W-1:0] pte_base_reg;
    logic [DATA_W-1:0] pde_base_reg;
    logic [DATA_W-1:0] ppe_base_reg;
    logic [DATA_W-1:0] pxe_base_reg;

    // Walk state.
    logic              walk_busy_reg;
    logic              walk_busy_next;
    logic [LVL_W-1:0]  walk_level_reg;
    logic [LVL_W-1:0]  walk_level_next;
    logic [VA_W-1:0]   saved_vaddr_reg;
    logic [VA_W-1:0]   saved_vaddr_next;

    // Input stage.
    logic              in_valid_reg;
    walk_item_t        in_item_reg;

    // Result stage.
    logic              res_valid_reg;
    walk_result_t      res_item_reg;

    // Stage control.
    logic              cmd_fire;
    logic              stage_fire;
    logic              out_free;
    logic              has_result;
    walk_result_t      res_item_next;

    // Walk datapath.
    logic [VA_W-1:0]   addr_va;
    logic [LVL_W-1:0]  addr_level;
    logic [DATA_W-1:0] addr_base;
    logic [DATA_W-1:0] addr_index;
    logic [DATA_W-1:0] entry_address;
    logic [DATA_W-1:0] page_offset;
    logic [DATA_W-1:0] frame_address;
    logic              entry_valid;
    logic              entry_large;
    logic              walk_ends;

    //------------------------------------------------------------------
    // Configuration writes. The register index covers exactly the four
    // base registers.
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pte_base_reg <= '0;
            pde_base_reg <= '0;
            ppe_base_reg <= '0;
            pxe_base_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_PTE_BASE: pte_base_reg <= cfg_data;
                REG_PDE_BASE: pde_base_reg <= cfg_data;
                REG_PPE_BASE: ppe_base_reg <= cfg_data;
                REG_PXE_BASE: pxe_base_reg <= cfg_data;
                default:      pte_base_reg <= pte_base_reg;
            endcase
        end
    end

    //------------------------------------------------------------------
    // Handshakes. The input register moves on whenever its content
    // either gives no result or finds room in the result register.
    //------------------------------------------------------------------
    assign out_free   = !res_valid_reg || res.ready;
    assign stage_fire = in_valid_reg && (!has_result || out_free);
    assign cmd.ready  = !in_valid_reg || stage_fire;
    assign cmd_fire   = cmd.valid && cmd.ready;

    assign res.valid   = res_valid_reg;
    assign res.payload = res_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            in_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            in_item_reg <= cmd.payload;
        end
    end

    //------------------------------------------------------------------
    // Walk logic. A start reads the top-level entry of the new address;
    // a response that continues the walk reads the next level's entry of
    // the saved address.
    //------------------------------------------------------------------
    assign entry_valid = in_item_reg.entry_data[VALID_POS];
    assign entry_large = in_item_reg.entry_data[LARGE_POS];
    assign walk_ends   = !entry_valid || (walk_level_reg == LAST_LEVEL) || entry_large;

    always_comb
    begin
        if (in_item_reg.opcode == OP_TRANSLATE)
        begin
            addr_va    = in_item_reg.virt_addr;
            addr_level = TOP_LEVEL;
        end
        else
        begin
            addr_va    = saved_vaddr_reg;
            addr_level = walk_level_reg + LVL_W'(1);
        end
    end

    // Entry index: the virtual address bits above the level's shift,
    // scaled by the 8-byte entry size.
    always_comb
    begin
        case (addr_level)
            2'd0:
            begin
                addr_base  = pxe_base_reg;
                addr_index = DATA_W'({addr_va[47:39], 3'b000});
            end
            2'd1:
            begin
                addr_base  = ppe_base_reg;
                addr_index = DATA_W'({addr_va[47:30], 3'b000});
            end
            2'd2:
            begin
                addr_base  = pde_base_reg;
                addr_index = DATA_W'({addr_va[47:21], 3'b000});
            end
            default:
            begin
                addr_base  = pte_base_reg;
                addr_index = DATA_W'({addr_va[47:12], 3'b000});
            end
        endcase
    end

    assign entry_address = addr_index + addr_base;

    // Offset within the page that the current level maps: 512 GiB at the
    // top level down to 4 KiB at the last level.
    always_comb
    begin
        case (walk_level_reg)
            2'd0:    page_offset = DATA_W'(saved_vaddr_reg[38:0]);
            2'd1:    page_offset = DATA_W'(saved_vaddr_reg[29:0]);
            2'd2:    page_offset = DATA_W'(saved_vaddr_reg[20:0]);
            default: page_offset = DATA_W'(saved_vaddr_reg[11:0]);
        endcase
    end

    assign frame_address = DATA_W'({in_item_reg.entry_data[47:12], 12'h000}) + page_offset;

    always_comb
    begin
        walk_busy_next   = walk_busy_reg;
        walk_level_next  = walk_level_reg;
        saved_vaddr_next = saved_vaddr_reg;
        has_result       = 1'b0;

        res_item_next.result_kind = KIND_READ;
        res_item_next.read_addr   = entry_address;
        res_item_next.phys_addr   = '0;
        res_item_next.not_present = 1'b0;

        if (in_item_reg.opcode == OP_TRANSLATE)
        begin
            // A translate during a walk is dropped.
            if (!walk_busy_reg)
            begin
                has_result       = 1'b1;
                walk_busy_next   = 1'b1;
                walk_level_next  = TOP_LEVEL;
                saved_vaddr_next = in_item_reg.virt_addr;
            end
        end
        else if (walk_busy_reg)
        begin
            has_result = 1'b1;
            if (walk_ends)
            begin
                walk_busy_next            = 1'b0;
                walk_level_next           = TOP_LEVEL;
                res_item_next.result_kind = KIND_DONE;
                res_item_next.read_addr   = '0;
                res_item_next.not_present = !entry_valid;
                res_item_next.phys_addr   = entry_valid ? frame_address : '0;
            end
            else
            begin
                walk_level_next = walk_level_reg + LVL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_busy_reg   <= 1'b0;
            walk_level_reg  <= TOP_LEVEL;
            saved_vaddr_reg <= '0;
        end
        else if (stage_fire)
        begin
            walk_busy_reg   <= walk_busy_next;
            walk_level_reg  <= walk_level_next;
            saved_vaddr_reg <= saved_vaddr_next;
        end
    end

    //------------------------------------------------------------------
    // Result register.
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            res_valid_reg <= stage_fire && has_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_fire && has_result && out_free)
        begin
            res_item_reg <= res_item_next;
        end
    end

    //------------------------------------------------------------------
    // Assertions.
    //------------------------------------------------------------------

    // An idle walker always sits at the top level.
    assert property (@(posedge clk) disable iff (!rst_n)
        !walk_busy_reg |-> (walk_level_reg == TOP_LEVEL))
    else $error("walker idle away from the top level");

    // A finished translation leaves the walker idle; a read request keeps it busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_fire && has_result) |=>
            (walk_busy_reg == (res_item_reg.result_kind == KIND_READ)))
    else $error("walk state disagrees with the result just produced");

    // A translation that hit an invalid entry reports physical address zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_item_reg.not_present) |->
            (res_item_reg.result_kind == KIND_DONE && res_item_reg.phys_addr == '0))
    else $error("not-present result carries a physical address");

endmodule

// ----- dv/four_level_page_walker_tb.sv -----
// Self-checking testbench for the four-level page walker.
`timescale 1ns / 1ps

// The testbench drives walk transactions into the cmd channel and checks every
// transaction on the res channel against its own model of the walker.
//
// Stimulus runs in phases. Each phase first loads a new set of base
// registers while the block is idle. It then queues translations with random
// addresses, each followed by page table entries that end the walk:
//  - on a not-present entry,
//  - on a large page at one of the upper levels,
//  - at the last level.
// Some noise goes in as well: stray responses, translations that arrive during
// a walk, and walks that are abandoned part way. The first phase opens with a
// short directed sequence that covers the address extremes and every way a
// walk can end.
//
// A clocked driver feeds the cmd channel from a queue that the stimulus fills.
// A clocked monitor runs the model on every accepted command and compares each
// accepted result with the oldest expectation.
module four_level_page_walker_tb;
    import flpw_pkg::*;

    localparam time         CLK_PERIOD     = 20ns;
    localparam int unsigned RESET_CYCLES   = 11;
    // A command passes the input register and then the result register, so
    // SETTLE_CYCLES covers a dropped command that is still inside the pipeline.
    localparam int unsigned SETTLE_CYCLES  = 6;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned PHASE_COUNT    = 7;
    localparam int unsigned ITEMS_PER_PHASE = 160;

    // Entry address bits 47..12 serve both as the table index source and as
    // the frame field of an entry.
    localparam logic [DATA_W-1:0] FRAME_MASK = 64'h0000_FFFF_FFFF_F000;

    typedef enum int unsigned
    {
        ENT_INVALID,
        ENT_TABLE,
        ENT_LARGE
    } entry_kind_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;

    flpw_chan_if #(.payload_t(walk_item_t))   cmd_if ();
    flpw_chan_if #(.payload_t(walk_result_t)) res_if ();

    four_level_page_walker i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_if),
        .res       (res_if)
    );

    // Model state: the walk in progress and the base registers as written.
    logic                 in_walk;
    logic [LVL_W-1:0]     cur_level;
    logic [VA_W-1:0]      walk_vaddr;
    logic [DATA_W-1:0]    base_regs [4];

    walk_item_t   pending_cmds[$];
    walk_result_t expected_results[$];

    // Handshake flags are sampled at the rising edge and used by the drivers
    // at the following falling edge.
    bit           cmd_took;
    bit           res_took;
    bit           cmd_calm;
    bit           res_calm;
    int unsigned  cmd_wait;
    int unsigned  res_wait;

    int unsigned  error_count;
    int unsigned  idle_cycles;
    int unsigned  items_queued;
    int unsigned  read_count;
    int unsigned  done_count;
    int unsigned  absent_count;
    int unsigned  dropped_count;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // Address of the entry for one level: the virtual address bits 47..12,
    // shifted down by the level's shift, scaled by the entry size and added
    // to the level's self-map base. The top level uses pxe_base, the last
    // level uses pte_base, so the register index runs opposite to the level.
    function automatic logic [DATA_W-1:0] entry_address(input logic [LVL_W-1:0] lvl);
        int unsigned       sh;
        logic [DATA_W-1:0] index_bits;
        sh         = 39 - 9 * lvl;
        index_bits = {16'h0, walk_vaddr} & FRAME_MASK;
        return ((index_bits >> sh) << 3) + base_regs[LAST_LEVEL - lvl];
    endfunction

    // Advances the model by one accepted command. Returns 1 when the command
    // produces a result, and 0 when the block drops the command.
    function automatic bit walk_predict(input walk_item_t item, output walk_result_t res);
        logic [DATA_W-1:0] e;
        int unsigned       sh;
        res = '0;
        if (item.opcode == OP_TRANSLATE)
        begin
            // A translation that arrives during a walk is dropped.
            if (in_walk)
                return 1'b0;
            walk_vaddr      = item.virt_addr;
            cur_level       = TOP_LEVEL;
            in_walk         = 1'b1;
            res.result_kind = KIND_READ;
            res.read_addr   = entry_address(TOP_LEVEL);
            return 1'b1;
        end
        // A response that arrives while idle is dropped.
        if (!in_walk)
            return 1'b0;
        e  = item.entry_data;
        sh = 39 - 9 * cur_level;
        if (!e[VALID_POS])
        begin
            in_walk         = 1'b0;
            cur_level       = TOP_LEVEL;
            res.result_kind = KIND_DONE;
            res.not_present = 1'b1;
            return 1'b1;
        end
        if (cur_level == LAST_LEVEL || e[LARGE_POS])
        begin
            // The frame is kept in place and the offset below the level's
            // shift comes from the virtual address.
            res.result_kind = KIND_DONE;
            res.phys_addr   = (e & FRAME_MASK) + ({16'h0, walk_vaddr} & ((64'd1 << sh) - 1));
            in_walk         = 1'b0;
            cur_level       = TOP_LEVEL;
            return 1'b1;
        end
        cur_level       = cur_level + 1'b1;
        res.result_kind = KIND_READ;
        res.read_addr   = entry_address(cur_level);
        return 1'b1;
    endfunction

    function automatic logic [VA_W-1:0] rand_vaddr();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return {16'($urandom), 32'($urandom)};
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] make_entry(input entry_kind_t kind);
        logic [DATA_W-1:0] e;
        e = {$urandom, $urandom};
        case (kind)
            ENT_INVALID:
                e[VALID_POS] = 1'b0;
            ENT_TABLE:
            begin
                e[VALID_POS] = 1'b1;
                e[LARGE_POS] = 1'b0;
            end
            default:
            begin
                e[VALID_POS] = 1'b1;
                e[LARGE_POS] = 1'b1;
            end
        endcase
        return e;
    endfunction

    task automatic push_cmd(input opcode_t op, input logic [VA_W-1:0] va,
                            input logic [DATA_W-1:0] data);
        walk_item_t item;
        item.opcode     = op;
        item.virt_addr  = va;
        item.entry_data = data;
        pending_cmds.push_back(item);
        items_queued++;
    endtask

    // Queues one walk with random content. Most walks are complete. A few
    // carry a stray response in front of them, a translation in the middle,
    // or stop early and leave the block waiting for an entry.
    task automatic queue_random_walk();
        int unsigned pick;
        int unsigned lvl;
        bit          finished;
        if ($urandom_range(0, 99) < 4)
            push_cmd(OP_RESPONSE, rand_vaddr(), make_entry(entry_kind_t'($urandom_range(0, 2))));
        push_cmd(OP_TRANSLATE, rand_vaddr(), {$urandom, $urandom});
        lvl      = 0;
        finished = 1'b0;
        while (!finished)
        begin
            if ($urandom_range(0, 99) < 3)
                push_cmd(OP_TRANSLATE, rand_vaddr(), {$urandom, $urandom});
            pick = $urandom_range(0, 99);
            if (pick < 2)
            begin
                finished = 1'b1;
            end
            else if (pick < 12)
            begin
                push_cmd(OP_RESPONSE, rand_vaddr(), make_entry(ENT_INVALID));
                finished = 1'b1;
            end
            else if (lvl == 3)
            begin
                // The large-page bit has no meaning at the last level.
                push_cmd(OP_RESPONSE, rand_vaddr(),
                         make_entry(entry_kind_t'($urandom_range(0, 1) ? ENT_LARGE : ENT_TABLE)));
                finished = 1'b1;
            end
            else if (pick < 27)
            begin
                push_cmd(OP_RESPONSE, rand_vaddr(), make_entry(ENT_LARGE));
                finished = 1'b1;
            end
            else
            begin
                push_cmd(OP_RESPONSE, rand_vaddr(), make_entry(ENT_TABLE));
                lvl++;
            end
        end
    endtask

    // Waits until every queued command is taken and every result is in. If
    // the model is left inside a walk, a not-present entry ends it. The
    // registers are reloaded only once no walk is in progress.
    task automatic settle_block();
        do
        begin
            while (pending_cmds.size() != 0 || cmd_if.valid || expected_results.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
            if (in_walk)
                push_cmd(OP_RESPONSE, rand_vaddr(), make_entry(ENT_INVALID));
        end
        while (pending_cmds.size() != 0);
    endtask

    task automatic write_base(input cfg_index_t idx, input logic [DATA_W-1:0] value);
        @(negedge clk);
        cfg_we         <= 1'b1;
        cfg_index      <= idx;
        cfg_data       <= value;
        base_regs[idx]  = value;
    endtask

    // Builds a recursive self-map at a random slot in the upper half of the
    // address space, in the way an operating system lays one out.
    task automatic load_self_map();
        logic [DATA_W-1:0] slot;
        logic [DATA_W-1:0] pte;
        logic [DATA_W-1:0] pde;
        logic [DATA_W-1:0] ppe;
        slot = $urandom_range(256, 511);
        pte  = 64'hFFFF_0000_0000_0000 | (slot << 39);
        pde  = pte + (slot << 30);
        ppe  = pde + (slot << 21);
        write_base(REG_PTE_BASE, pte);
        write_base(REG_PDE_BASE, pde);
        write_base(REG_PPE_BASE, ppe);
        write_base(REG_PXE_BASE, ppe + (slot << 12));
    endtask

    // Directed sequence: address extremes and every way a walk can end.
    task automatic queue_directed();
        push_cmd(OP_RESPONSE, '1, make_entry(ENT_TABLE));
        // A large page at the top level, with all address bits set.
        push_cmd(OP_TRANSLATE, '1, '1);
        push_cmd(OP_RESPONSE, '0, 64'hFFFF_FFFF_FFFF_FFFF);
        // A not-present entry at the top level, with all address bits clear.
        push_cmd(OP_TRANSLATE, '0, '0);
        push_cmd(OP_RESPONSE, '1, '0);
        // A large page at the directory pointer level.
        push_cmd(OP_TRANSLATE, 48'h8000_0000_0000, '0);
        push_cmd(OP_RESPONSE, '0, 64'h0000_FFFF_FFFF_F001);
        push_cmd(OP_RESPONSE, '0, 64'h8000_0000_0000_0081);
        // A large page at the directory level.
        push_cmd(OP_TRANSLATE, rand_vaddr(), '1);
        push_cmd(OP_RESPONSE, '0, make_entry(ENT_TABLE));
        push_cmd(OP_RESPONSE, '0, make_entry(ENT_TABLE));
        push_cmd(OP_RESPONSE, '0, make_entry(ENT_LARGE));
        // A full walk to a small page. The last entry has the large-page bit
        // set, which must not change the result.
        push_cmd(OP_TRANSLATE, '1, '0);
        push_cmd(OP_RESPONSE, '0, 64'hFFFF_FFFF_FFFF_FF7F);
        push_cmd(OP_RESPONSE, '0, 64'hFFFF_FFFF_FFFF_FF7F);
        push_cmd(OP_RESPONSE, '0, 64'hFFFF_FFFF_FFFF_FF7F);
        push_cmd(OP_RESPONSE, '0, 64'hFFFF_FFFF_FFFF_FFFF);
        // A translation during a walk is dropped. The walk then ends on a
        // not-present entry at the last level.
        push_cmd(OP_TRANSLATE, rand_vaddr(), '0);
        push_cmd(OP_TRANSLATE, '1, '1);
        push_cmd(OP_RESPONSE, '1, make_entry(ENT_TABLE));
        push_cmd(OP_RESPONSE, '1, make_entry(ENT_TABLE));
        push_cmd(OP_RESPONSE, '1, make_entry(ENT_TABLE));
        push_cmd(OP_RESPONSE, '1, 64'hFFFF_FFFF_FFFF_FFFE);
        // A not-present entry at the directory pointer level.
        push_cmd(OP_TRANSLATE, rand_vaddr(), '0);
        push_cmd(OP_RESPONSE, '0, make_entry(ENT_TABLE));
        push_cmd(OP_RESPONSE, '0, make_entry(ENT_INVALID));
    endtask

    // Command driver. A new transaction is offered at the falling edge once the
    // previous one has been taken and the drawn gap has run out. From time to
    // time the driver switches to a calm stretch with no gaps.
    always @(negedge clk)
    begin
        if (rst_n && (cmd_took || !cmd_if.valid))
        begin
            if (cmd_wait > 0)
            begin
                cmd_if.valid <= 1'b0;
                cmd_wait--;
            end
            else if (pending_cmds.size() != 0)
            begin
                cmd_if.payload <= pending_cmds.pop_front();
                cmd_if.valid   <= 1'b1;
                if ($urandom_range(0, 63) == 0)
                    cmd_calm = !cmd_calm;
                cmd_wait = cmd_calm ? 0 : $urandom_range(0, 4);
            end
            else
            begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // Result receiver. After each accepted result, ready drops for a drawn
    // gap. It also has calm stretches with no stalls.
    always @(negedge clk)
    begin
        if (res_took)
        begin
            if ($urandom_range(0, 63) == 0)
                res_calm = !res_calm;
            res_wait = res_calm ? 0 : $urandom_range(0, 4);
        end
        if (res_wait > 0)
        begin
            res_if.ready <= 1'b0;
            res_wait--;
        end
        else
        begin
            res_if.ready <= 1'b1;
        end
    end

    // Monitor: checks results, runs the model on accepted commands and keeps
    // the watchdog.
    always @(posedge clk)
    begin : monitor
        walk_result_t predicted;
        walk_result_t want;
        walk_result_t got;
        cmd_took = rst_n && cmd_if.valid && cmd_if.ready;
        res_took = rst_n && res_if.valid && res_if.ready;

        if (res_took)
        begin
            got = res_if.payload;
            if (expected_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, got kind %0d read_addr %h phys_addr %h np %b",
                         $time, got.result_kind, got.read_addr, got.phys_addr,
                         got.not_present);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.result_kind !== want.result_kind)
                begin
                    error_count++;
                    $display("%0t: result_kind mismatch, expected %0d, got %0d",
                             $time, want.result_kind, got.result_kind);
                end
                if (got.read_addr !== want.read_addr)
                begin
                    error_count++;
                    $display("%0t: read_addr mismatch, expected %h, got %h",
                             $time, want.read_addr, got.read_addr);
                end
                if (got.phys_addr !== want.phys_addr)
                begin
                    error_count++;
                    $display("%0t: phys_addr mismatch, expected %h, got %h",
                             $time, want.phys_addr, got.phys_addr);
                end
                if (got.not_present !== want.not_present)
                begin
                    error_count++;
                    $display("%0t: not_present mismatch, expected %b, got %b",
                             $time, want.not_present, got.not_present);
                end
                if (want.result_kind == KIND_READ)
                    read_count++;
                else
                    done_count++;
                if (want.not_present)
                    absent_count++;
            end
        end

        if (cmd_took)
        begin
            if (walk_predict(cmd_if.payload, predicted))
                expected_results.push_back(predicted);
            else
                dropped_count++;
        end

        if (cmd_took || res_took)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles, %0d commands queued, %0d results due",
                     $time, idle_cycles, pending_cmds.size(), expected_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_PTE_BASE;
        cfg_data       = '0;
        cmd_if.valid   = 1'b0;
        cmd_if.payload = '0;
        res_if.ready   = 1'b0;
        in_walk        = 1'b0;
        cur_level      = TOP_LEVEL;
        walk_vaddr     = '0;
        foreach (base_regs[i])
            base_regs[i] = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                1:
                begin
                    write_base(REG_PTE_BASE, '0);
                    write_base(REG_PDE_BASE, '0);
                    write_base(REG_PPE_BASE, '0);
                    write_base(REG_PXE_BASE, '0);
                end
                2:
                begin
                    write_base(REG_PTE_BASE, '1);
                    write_base(REG_PDE_BASE, '1);
                    write_base(REG_PPE_BASE, '1);
                    write_base(REG_PXE_BASE, '1);
                end
                3:
                begin
                    write_base(REG_PTE_BASE, {$urandom, $urandom});
                    write_base(REG_PDE_BASE, {$urandom, $urandom});
                    write_base(REG_PPE_BASE, {$urandom, $urandom});
                    write_base(REG_PXE_BASE, {$urandom, $urandom});
                end
                4:
                begin
                    // Bases at the top of the address space make the entry
                    // address sums wrap.
                    write_base(REG_PTE_BASE, 64'hFFFF_FFFF_FFFF_FFF8);
                    write_base(REG_PDE_BASE, 64'hFFFF_FFFF_FFFF_F000);
                    write_base(REG_PPE_BASE, 64'h8000_0000_0000_0000);
                    write_base(REG_PXE_BASE, 64'hFFFF_FFFF_FFFF_FFFF);
                end
                5:
                begin
                    write_base(REG_PTE_BASE, 64'hAAAA_AAAA_AAAA_AAAA);
                    write_base(REG_PDE_BASE, 64'h5555_5555_5555_5555);
                    write_base(REG_PPE_BASE, 64'hAAAA_AAAA_AAAA_AAAA);
                    write_base(REG_PXE_BASE, 64'h5555_5555_5555_5555);
                end
                default:
                    load_self_map();
            endcase
            @(negedge clk);
            cfg_we <= 1'b0;

            if (phase == 0)
                queue_directed();
            items_queued = 0;
            while (items_queued < ITEMS_PER_PHASE)
                queue_random_walk();
            settle_block();
        end

        $display("Checked %0d entry read requests and %0d finished walks (%0d not present)",
                 read_count, done_count, absent_count);
        $display("over %0d base register settings; %0d commands were dropped by the block.",
                 PHASE_COUNT, dropped_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
sv/flpw_pkg.sv
sv/flpw_chan_if.sv
sv/four_level_page_walker.sv
dv/four_level_page_walker_tb.sv
